// ----- hw/rtl/sbi_pkg.sv -----
package sbi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIR_W     = 18;
    localparam int LEN_W     = 31;
    localparam int TOL_W     = 16;

    localparam int DIFF_W = COORD_W + 1;
    localparam int NUM_W  = DIFF_W + FRAC_BITS;
    localparam int QUO_W  = DIFF_W;
    localparam int TOP_W  = NUM_W - QUO_W;
    localparam int DEN_W  = DIR_W;
    localparam int CMP_W  = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 1 + (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int PROD_W  = COORD_W + DIR_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int PT_W    = ((SHIFT_W > COORD_W) ? SHIFT_W : COORD_W) + 2;

    localparam int NFACE = 6;

    localparam int IN_DATA_W  = ((3 * COORD_W + 3 * DIR_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * COORD_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p;
        logic [2:0][DIR_W-1:0]   d;
        logic [LEN_W-1:0]        len;
        logic                    touch;
        logic [2:0]              axis_ok;
    } side_t;

endpackage

// ----- hw/rtl/sbi_divider.sv -----
module sbi_divider (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [sbi_pkg::NUM_W-1:0] num_mag,
    input  logic [sbi_pkg::DEN_W-1:0] den,
    input  logic                      neg,
    output logic [sbi_pkg::QUO_W-1:0] quo_mag,
    output logic                      quo_neg,
    output logic                      quo_ovf
);
    import sbi_pkg::*;

    logic [DEN_W-1:0] rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] low_reg  [DIV_STAGES];
    logic [QUO_W-1:0] low_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES];
    logic [DEN_W-1:0] den_next [DIV_STAGES];
    logic             neg_reg  [DIV_STAGES];
    logic             neg_next [DIV_STAGES];
    logic             ovf_reg  [DIV_STAGES];
    logic             ovf_next [DIV_STAGES];

    // The first stage flags quotients of 2^QUO_W or more; the others retire up to
    // DIV_STEPS restoring steps each, the last only those left of QUO_W.
    always_comb begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        trial = '0;
        rem_next[0] = DEN_W'(num_mag[NUM_W-1 -: TOP_W]);
        low_next[0] = num_mag[QUO_W-1:0];
        quo_next[0] = '0;
        den_next[0] = den;
        neg_next[0] = neg;
        ovf_next[0] = CMP_W'(num_mag[NUM_W-1 -: TOP_W]) >= CMP_W'(den);
        for (int s = 1; s < DIV_STAGES; s++) begin
            rem = rem_reg[s-1];
            low = low_reg[s-1];
            quo = quo_reg[s-1];
            for (int k = 0; k < DIV_STEPS; k++) begin
                if ((s - 1) * DIV_STEPS + k < QUO_W) begin
                    trial = {rem, low[QUO_W-1]};
                    low   = low << 1;
                    if (trial >= {1'b0, den_reg[s-1]}) begin
                        rem = DEN_W'(trial - {1'b0, den_reg[s-1]});
                        quo = {quo[QUO_W-2:0], 1'b1};
                    end else begin
                        rem = trial[DEN_W-1:0];
                        quo = {quo[QUO_W-2:0], 1'b0};
                    end
                end
            end
            rem_next[s] = rem;
            low_next[s] = low;
            quo_next[s] = quo;
            den_next[s] = den_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            ovf_next[s] = ovf_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_next[s];
                neg_reg[s] <= neg_next[s];
                ovf_reg[s] <= ovf_next[s];
            end
        end
    end

    assign quo_mag = quo_reg[DIV_STAGES-1];
    assign quo_neg = neg_reg[DIV_STAGES-1];
    assign quo_ovf = ovf_reg[DIV_STAGES-1];

endmodule

// ----- hw/rtl/sbi_face.sv -----
module sbi_face (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [sbi_pkg::COORD_W-1:0] lam,
    input  logic signed [sbi_pkg::DIR_W-1:0]   dir_b,
    input  logic signed [sbi_pkg::DIR_W-1:0]   dir_c,
    input  logic signed [sbi_pkg::COORD_W-1:0] p_b,
    input  logic signed [sbi_pkg::COORD_W-1:0] p_c,
    input  logic signed [sbi_pkg::COORD_W-1:0] lo_b,
    input  logic signed [sbi_pkg::COORD_W-1:0] hi_b,
    input  logic signed [sbi_pkg::COORD_W-1:0] lo_c,
    input  logic signed [sbi_pkg::COORD_W-1:0] hi_c,
    input  logic        [sbi_pkg::TOL_W-1:0]   eps,
    input  logic                               touch,
    output logic                               ok,
    output logic signed [sbi_pkg::COORD_W-1:0] lam_out
);
    import sbi_pkg::*;

    logic signed [PROD_W-1:0]  prod_b_reg;
    logic signed [PROD_W-1:0]  prod_c_reg;
    logic signed [COORD_W-1:0] pb_reg;
    logic signed [COORD_W-1:0] pc_reg;
    logic signed [COORD_W-1:0] lam1_reg;
    logic                      touch1_reg;
    logic signed [COORD_W-1:0] lam2_reg;
    logic                      ok_reg;
    logic                      ok_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_b_reg <= lam * dir_b;
            prod_c_reg <= lam * dir_c;
            pb_reg     <= p_b;
            pc_reg     <= p_c;
            lam1_reg   <= lam;
            touch1_reg <= touch;
            lam2_reg   <= lam1_reg;
            ok_reg     <= ok_next;
        end
    end

    always_comb begin
        logic signed [SHIFT_W-1:0] sh_b;
        logic signed [SHIFT_W-1:0] sh_c;
        logic signed [PT_W-1:0]    cb;
        logic signed [PT_W-1:0]    cc;
        logic signed [PT_W-1:0]    e;
        logic signed [PT_W-1:0]    lob;
        logic signed [PT_W-1:0]    hib;
        logic signed [PT_W-1:0]    loc;
        logic signed [PT_W-1:0]    hic;
        sh_b = SHIFT_W'(prod_b_reg >>> FRAC_BITS);
        sh_c = SHIFT_W'(prod_c_reg >>> FRAC_BITS);
        cb   = PT_W'(pb_reg) + PT_W'(sh_b);
        cc   = PT_W'(pc_reg) + PT_W'(sh_c);
        e    = PT_W'($signed({1'b0, eps}));
        if (touch1_reg) begin
            lob = PT_W'(lo_b) + e;
            hib = PT_W'(hi_b) - e;
            loc = PT_W'(lo_c) + e;
            hic = PT_W'(hi_c) - e;
        end else begin
            lob = PT_W'(lo_b) - e;
            hib = PT_W'(hi_b) + e;
            loc = PT_W'(lo_c) - e;
            hic = PT_W'(hi_c) + e;
        end
        ok_next = (cb > lob) && (cb < hib) && (cc > loc) && (cc < hic);
    end

    assign ok      = ok_reg;
    assign lam_out = lam2_reg;

endmodule

// ----- hw/rtl/segment_box_intersect_core.sv -----
// Channel  Direction  Contents
// s_       in         tdata: start x/y/z, dir x/y/z, length; tuser: touch excluded
// m_       out        tdata: entry, exit distance; tuser: hit
// cfg_     in         box bounds and tolerance, write only
//
// One request is taken per cycle while the skid register is empty; the
// dividers are restoring and retire four quotient bits per stage. Reset is
// synchronous, clears the valid bits and box bounds and sets the tolerance
// to one. A stalled result waits in the output register and a second one in
// the skid register; the pipeline halts only while the skid is full.
module segment_box_intersect_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, start_z, dir_x, dir_y, dir_z, seg_length, zero fill
    input  logic [sbi_pkg::IN_DATA_W-1:0]      s_tdata,
    // touch_excluded
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // entry_distance, exit_distance
    output logic [sbi_pkg::OUT_DATA_W-1:0]     m_tdata,
    // hit
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [sbi_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [sbi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sbi_pkg::*;

    localparam int Q_IDX  = DIV_STAGES + 1;
    localparam int PIPE_N = DIV_STAGES + 5;
    localparam int DIR_OFS = 3 * COORD_W;
    localparam int LEN_OFS = DIR_OFS + 3 * DIR_W;
    localparam logic [QUO_W-1:0] Q_POS_LIM = QUO_W'({(COORD_W-1){1'b1}});
    localparam logic [QUO_W-1:0] Q_NEG_LIM = QUO_W'(1) << (COORD_W - 1);
    localparam logic [COORD_W-1:0] LAM_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] LAM_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [COORD_W-1:0] box_lo_reg [3];
    logic [COORD_W-1:0] box_hi_reg [3];
    logic [TOL_W-1:0]   tol_reg;

    logic  adv;
    logic  vld_reg [PIPE_N];
    side_t sb_reg  [PIPE_N];
    side_t sb_next;

    logic [NUM_W-1:0] num_reg  [NFACE];
    logic [NUM_W-1:0] num_next [NFACE];
    logic [DEN_W-1:0] den_reg  [NFACE];
    logic [DEN_W-1:0] den_next [NFACE];
    logic             neg_reg  [NFACE];
    logic             neg_next [NFACE];

    logic [QUO_W-1:0]          quo_mag [NFACE];
    logic                      quo_neg [NFACE];
    logic                      quo_ovf [NFACE];
    logic signed [COORD_W-1:0] lam_reg  [NFACE];
    logic signed [COORD_W-1:0] lam_next [NFACE];

    logic                      face_ok  [NFACE];
    logic signed [COORD_W-1:0] face_lam [NFACE];

    logic                      any_reg;
    logic                      any_next;
    logic signed [COORD_W-1:0] entry_reg;
    logic signed [COORD_W-1:0] entry_next;
    logic signed [COORD_W-1:0] exit_reg;
    logic signed [COORD_W-1:0] exit_next;

    logic                  res_hit;
    logic [OUT_DATA_W-1:0] res_data;
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  skid_valid_reg;
    logic                  skid_hit_reg;
    logic [OUT_DATA_W-1:0] skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
            tol_reg <= TOL_W'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data[COORD_W-1:0];
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data[COORD_W-1:0];
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data[COORD_W-1:0];
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data[COORD_W-1:0];
                REG_TOLERANCE: tol_reg       <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_comb begin
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        dmag_ext;
        logic [DEN_W-1:0]         dmag;
        logic signed [DIR_W-1:0]  dv;
        logic [COORD_W-1:0]       face;
        diff     = '0;
        dmag_ext = '0;
        for (int a = 0; a < 3; a++) begin
            sb_next.p[a] = s_tdata[a*COORD_W +: COORD_W];
            sb_next.d[a] = s_tdata[DIR_OFS + a*DIR_W +: DIR_W];
        end
        sb_next.len   = s_tdata[LEN_OFS +: LEN_W];
        sb_next.touch = s_tuser;
        for (int a = 0; a < 3; a++) begin
            dv   = $signed(sb_next.d[a]);
            dmag = dv[DIR_W-1] ? DEN_W'(-dv) : DEN_W'(dv);
            sb_next.axis_ok[a] = 32'(dmag) > 32'(tol_reg);
            for (int h = 0; h < 2; h++) begin
                face = (h == 1) ? box_hi_reg[a] : box_lo_reg[a];
                diff = DIFF_W'($signed(face)) - DIFF_W'($signed(sb_next.p[a]));
                dmag_ext = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
                num_next[2*a+h] = {dmag_ext, {FRAC_BITS{1'b0}}};
                den_next[2*a+h] = dmag;
                neg_next[2*a+h] = diff[DIFF_W-1] ^ dv[DIR_W-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_N; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_N; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb_reg[0] <= sb_next;
            for (int i = 1; i < PIPE_N; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
            for (int f = 0; f < NFACE; f++) begin
                num_reg[f] <= num_next[f];
                den_reg[f] <= den_next[f];
                neg_reg[f] <= neg_next[f];
                lam_reg[f] <= lam_next[f];
            end
            any_reg   <= any_next;
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
        end
    end

    for (genvar f = 0; f < NFACE; f++) begin : g_face
        localparam int A = f / 2;
        localparam int B = (A + 1) % 3;
        localparam int C = (A + 2) % 3;

        sbi_divider u_div (
            .aclk    (aclk),
            .en      (adv),
            .num_mag (num_reg[f]),
            .den     (den_reg[f]),
            .neg     (neg_reg[f]),
            .quo_mag (quo_mag[f]),
            .quo_neg (quo_neg[f]),
            .quo_ovf (quo_ovf[f])
        );

        sbi_face u_face (
            .aclk    (aclk),
            .en      (adv),
            .lam     (lam_reg[f]),
            .dir_b   ($signed(sb_reg[Q_IDX].d[B])),
            .dir_c   ($signed(sb_reg[Q_IDX].d[C])),
            .p_b     ($signed(sb_reg[Q_IDX].p[B])),
            .p_c     ($signed(sb_reg[Q_IDX].p[C])),
            .lo_b    ($signed(box_lo_reg[B])),
            .hi_b    ($signed(box_hi_reg[B])),
            .lo_c    ($signed(box_lo_reg[C])),
            .hi_c    ($signed(box_hi_reg[C])),
            .eps     (tol_reg),
            .touch   (sb_reg[Q_IDX].touch),
            .ok      (face_ok[f]),
            .lam_out (face_lam[f])
        );
    end

    // Quotients saturate to the signed coordinate range.
    always_comb begin
        for (int f = 0; f < NFACE; f++) begin
            if (quo_neg[f]) begin
                lam_next[f] = (quo_ovf[f] || quo_mag[f] > Q_NEG_LIM) ? $signed(LAM_MIN)
                            : $signed(-quo_mag[f][COORD_W-1:0]);
            end else begin
                lam_next[f] = (quo_ovf[f] || quo_mag[f] > Q_POS_LIM) ? $signed(LAM_MAX)
                            : $signed(quo_mag[f][COORD_W-1:0]);
            end
        end
    end

    always_comb begin
        logic take;
        any_next   = 1'b0;
        entry_next = '0;
        exit_next  = '0;
        for (int f = 0; f < NFACE; f++) begin
            take = face_ok[f] && sb_reg[Q_IDX+2].axis_ok[f/2];
            if (take) begin
                if (!any_next || face_lam[f] < entry_next) begin
                    entry_next = face_lam[f];
                end
                if (!any_next || face_lam[f] > exit_next) begin
                    exit_next = face_lam[f];
                end
                any_next = 1'b1;
            end
        end
    end

    always_comb begin
        logic signed [COORD_W+1:0] re;
        logic signed [COORD_W+1:0] lim;
        re  = sb_reg[PIPE_N-1].touch ? -(COORD_W+2)'($signed({1'b0, tol_reg}))
                                     : (COORD_W+2)'($signed({1'b0, tol_reg}));
        lim = (COORD_W+2)'($signed({1'b0, sb_reg[PIPE_N-1].len})) + re;
        res_hit  = any_reg && ((COORD_W+2)'(exit_reg) > -re)
                           && ((COORD_W+2)'(entry_reg) < lim);
        res_data = res_hit ? {exit_reg, entry_reg} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[PIPE_N-1];
            end
        end else if (vld_reg[PIPE_N-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            if (skid_valid_reg) begin
                m_hit_reg  <= skid_hit_reg;
                m_data_reg <= skid_data_reg;
            end else begin
                m_hit_reg  <= res_hit;
                m_data_reg <= res_data;
            end
        end else if (adv) begin
            skid_hit_reg  <= res_hit;
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_data_reg == '0))
        else $error("miss carries non-zero distances");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |->
            ($signed(m_data_reg[COORD_W-1:0]) <= $signed(m_data_reg[OUT_DATA_W-1:COORD_W])))
        else $error("entry distance lies beyond exit distance");

endmodule

// ----- bench/tb_segment_box_intersect_core.sv -----
`timescale 1ns / 100ps

module tb_segment_box_intersect_core;
    import sbi_pkg::*;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [17:0] dx, dy, dz;
        logic [30:0]        len;
        logic               touch;
    } segment_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] entry;
        logic signed [31:0] leave;
    } crossing_t;

    typedef struct {
        segment_t  seg;
        logic      known;
        crossing_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic [15:0] tol;

    crossing_t crossing_q[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int hits = 0;
    int cycles = 0;
    int src_idle = 0;
    int snk_idle = 0;
    int hold_off = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    stim_row_t rows[$];

    segment_box_intersect_core uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic signed [63:0] floor_q(input logic signed [63:0] v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic crossing_t predict_crossing(input segment_t s);
        crossing_t r;
        logic signed [63:0] p[3], d[3], elo[3], ehi[3];
        logic signed [63:0] eps, reps, face, num, lam, cb, cc, mag, entry, leave, lim;
        logic any;
        int b, c;
        p[0] = s.px; p[1] = s.py; p[2] = s.pz;
        d[0] = s.dx; d[1] = s.dy; d[2] = s.dz;
        eps = {48'd0, tol};
        reps = s.touch ? -eps : eps;
        any = 1'b0;
        entry = 0;
        leave = 0;
        for (int a = 0; a < 3; a++) begin
            elo[a] = 64'(box_lo[a]) - reps;
            ehi[a] = 64'(box_hi[a]) + reps;
        end
        for (int a = 0; a < 3; a++) begin
            b = (a + 1) % 3;
            c = (a + 2) % 3;
            mag = d[a] < 0 ? -d[a] : d[a];
            if (mag <= eps || d[a] == 0) continue;
            for (int f = 0; f < 2; f++) begin
                face = f ? 64'(box_hi[a]) : 64'(box_lo[a]);
                num = (face - p[a]) <<< FRAC_BITS;
                lam = num / d[a];
                if (lam > 64'sd2147483647) lam = 64'sd2147483647;
                if (lam < -64'sd2147483648) lam = -64'sd2147483648;
                cb = p[b] + floor_q(lam * d[b]);
                if (!(cb > elo[b] && cb < ehi[b])) continue;
                cc = p[c] + floor_q(lam * d[c]);
                if (!(cc > elo[c] && cc < ehi[c])) continue;
                if (!any) begin
                    entry = lam;
                    leave = lam;
                    any = 1'b1;
                end else begin
                    if (lam < entry) entry = lam;
                    if (lam > leave) leave = lam;
                end
            end
        end
        lim = $signed({33'd0, s.len}) + reps;
        r.hit = any && leave > -reps && entry < lim;
        r.entry = r.hit ? entry[31:0] : '0;
        r.leave = r.hit ? leave[31:0] : '0;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < 3) box_lo[idx] = val;
        else if (idx < 6) box_hi[idx - 3] = val;
        else if (idx == REG_TOLERANCE) tol = val[15:0];
    endtask

    task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz, input logic [15:0] t);
        write_reg(REG_BOX_MIN_X, lx);
        write_reg(REG_BOX_MIN_Y, ly);
        write_reg(REG_BOX_MIN_Z, lz);
        write_reg(REG_BOX_MAX_X, hx);
        write_reg(REG_BOX_MAX_Y, hy);
        write_reg(REG_BOX_MAX_Z, hz);
        write_reg(REG_TOLERANCE, {16'd0, t});
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge aclk);
        repeat (DIV_STAGES + 10) @(posedge aclk);
    endtask

    task automatic send_segment(input segment_t s, input logic known, input crossing_t exp);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'd0, s.len, s.dz, s.dy, s.dx, s.pz, s.py, s.px};
        s_tuser <= s.touch;
        crossing_q.push_back(known ? exp : predict_crossing(s));
        sent++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic signed [17:0] rand_dir();
        case ($urandom_range(5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom_range(3));
            3: return 18'($urandom);
            default: return 18'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            default: return $signed($urandom_range(40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic segment_t rand_segment();
        segment_t s;
        s.px = rand_coord(); s.py = rand_coord(); s.pz = rand_coord();
        s.dx = rand_dir(); s.dy = rand_dir(); s.dz = rand_dir();
        s.len = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(60 << 16));
        s.touch = $urandom_range(1);
        return s;
    endfunction

    function automatic segment_t mk(input logic [31:0] x, y, z, input logic [17:0] a, b, c,
                                    input logic [30:0] l, input logic t);
        segment_t s;
        s.px = x; s.py = y; s.pz = z; s.dx = a; s.dy = b; s.dz = c; s.len = l; s.touch = t;
        return s;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_off <= hold_off + 1;
            if (hold_off == 199) hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge aclk) begin
        crossing_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (crossing_q.size() == 0) begin
                $display("%0t: unexpected result %h hit %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                e = crossing_q.pop_front();
                checked++;
                if (e.hit) hits++;
                if (m_tuser !== e.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, e.hit, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== e.entry) begin
                    $display("%0t: entry expected %h actual %h", $time, e.entry, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== e.leave) begin
                    $display("%0t: exit expected %h actual %h", $time, e.leave, m_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    initial begin
        crossing_t none, c, c0;
        segment_t s;
        none = '{1'b0, 32'd0, 32'd0};
        c0 = '{1'b1, 32'sd65536, 32'sd65536};
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        tol = 16'd1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the box is a single point, which the tolerance widens enough to be met.
        rows.push_back('{mk(-32'sd65536, 0, 0, 18'sd65536, 0, 0, 31'h7fffffff, 1'b0), 1'b1, c0});
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, none});
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].res);
        rows.delete();
        wait_drained();

        set_box(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                16'd16);
        c = '{1'b1, 32'sd65536, 32'sd196608};
        rows.push_back('{mk(-32'sd131072, 0, 0, 18'sd65536, 0, 0, 31'd10 << 16, 1'b0), 1'b1, c});
        rows.push_back('{mk(-32'sd131072, 0, 0, 18'sd65536, 0, 0, 31'd100, 1'b0), 1'b1, none});
        rows.push_back('{mk(32'sd131072, 0, 0, -18'sd65536, 0, 0, 31'd10 << 16, 1'b1), 1'b0, none});
        rows.push_back('{mk(0, -32'sd131072, 0, 0, 18'sd65536, 0, 31'd10 << 16, 1'b0), 1'b0, none});
        rows.push_back('{mk(0, 0, 32'sd131072, 0, 0, -18'sd65536, 31'd10 << 16, 1'b1), 1'b0, none});
        rows.push_back('{mk(-32'sd131072, 32'sd65536, 0, 18'sd65536, 0, 0, 31'd10 << 16, 1'b0),
                         1'b0, none});
        rows.push_back('{mk(-32'sd131072, 32'sd65536, 0, 18'sd65536, 0, 0, 31'd10 << 16, 1'b1),
                         1'b0, none});
        rows.push_back('{mk(0, 0, 0, 18'sd8, 18'sd65536, 0, 31'd10 << 16, 1'b0), 1'b0, none});
        rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 18'sd1, -18'sd1, 18'sd65536,
                         31'h7fffffff, 1'b0), 1'b0, none});
        rows.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -18'sd65536, -18'sd65536,
                         -18'sd65536, 31'h7fffffff, 1'b1), 1'b0, none});
        rows.push_back('{mk(0, 0, 0, 18'h1ffff, 18'h20000, 18'h20001, 31'd0, 1'b0), 1'b0, none});
        rows.push_back('{mk(0, 0, 0, 18'sd40000, 18'sd40000, 18'sd30000, 31'd0, 1'b1), 1'b0, none});
        foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].res);
        wait_drained();

        set_box(32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536, -32'sd65536, -32'sd65536,
                16'd0);
        foreach (rows[i]) send_segment(rows[i].seg, 1'b0, none);
        wait_drained();
        set_box(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 16'hffff);
        foreach (rows[i]) send_segment(rows[i].seg, 1'b0, none);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = ph == 0 ? 23 : ph == 1 ? 55 : 0;
            snk_idle = ph == 0 ? 55 : ph == 1 ? 23 : 0;
            set_box($signed($urandom_range(10 << 16)) - (12 << 16),
                    $signed($urandom_range(10 << 16)) - (12 << 16),
                    $signed($urandom_range(10 << 16)) - (12 << 16),
                    $urandom_range(10 << 16), $urandom_range(10 << 16),
                    $urandom_range(10 << 16), 16'($urandom_range(1 << 12)));
            if (ph == 2) hold_go <= 1'b1;
            for (int i = 0; i < 200; i++) begin
                s = rand_segment();
                send_segment(s, 1'b0, none);
            end
            wait_drained();
        end

        $display("Sent %0d segment requests over seven box settings; %0d results checked, %0d hits.",
                 sent, checked, hits);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
